@@ rtl/core/ftwa_pkg.sv @@
// Package: shared types, constants and the rotate helper for the flow hash of the flow table.
package ftwa_pkg;

	localparam int BUCKETS = 1024;
	localparam int WAYS = 4;
	localparam int BKT_W = $clog2(BUCKETS);
	localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int ENTRIES = BUCKETS * WAYS;
	localparam int ENT_W = $clog2(ENTRIES);
	localparam int CNT_W = 13;
	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	localparam logic [2:0] ACT_LOOKUP = 3'd0;
	localparam logic [2:0] ACT_INSERT = 3'd1;
	localparam logic [2:0] ACT_TOUCH = 3'd2;
	localparam logic [2:0] ACT_TICK = 3'd3;
	localparam logic [2:0] ACT_SWEEP = 3'd4;
	localparam logic [2:0] ACT_CLEAR = 3'd5;

	localparam logic [0:0] REG_SEED = 1'd0;
	localparam logic [0:0] REG_TIMEOUT = 1'd1;

	typedef struct packed {
		logic [2:0] action;
		logic [31:0] src_ip;
		logic [31:0] dst_ip;
		logic [15:0] src_port;
		logic [15:0] dst_port;
		logic [7:0] protocol;
	} req_t;

	typedef struct packed {
		logic found;
		logic inserted;
		logic table_full;
		logic [9:0] bucket;
		logic [1:0] way;
		logic [12:0] removed_count;
	} rsp_t;

	// Controller to datapath commands.
	typedef struct packed {
		logic load;       // capture request, start hash
		logic hash_step;  // advance the mix by a round pair (one round in the last step)
		logic rd_way;     // read way addressed by way counter
		logic eval_way;   // evaluate registered way data
		logic commit;     // apply lookup/insert/touch result
		logic tick;
		logic sw_rd;      // read entry at sweep index
		logic sw_eval;    // evaluate sweep entry
		logic rsp_load;   // load result register
	} cmd_t;

	typedef struct packed {
		logic hash_done;
		logic ways_done;
		logic sw_last;
	} sts_t;

	function automatic logic [31:0] rotl(input logic [31:0] x, input int k);
		rotl = (x << k) | (x >> (32 - k));
	endfunction

endpackage

@@ rtl/core/ftwa_ctrl.sv @@
// Controller state machine for the flow table.
module ftwa_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic [2:0] in_action,
	input logic out_busy,
	input ftwa_pkg::sts_t sts,
	output logic take,
	output ftwa_pkg::cmd_t cmd
);
	import ftwa_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_HASH = 3'd1;
	localparam logic [2:0] ST_WAYS = 3'd2;
	localparam logic [2:0] ST_COMMIT = 3'd3;
	localparam logic [2:0] ST_SWEEP = 3'd4;
	localparam logic [2:0] ST_SWLAST = 3'd5;
	localparam logic [2:0] ST_DONE = 3'd6;

	logic [2:0] state_q;
	logic rd_pend_q;

	assign take = (state_q == ST_IDLE) && in_valid;

	always_comb begin
		cmd = '0;
		cmd.load = take;
		cmd.hash_step = (state_q == ST_HASH);
		cmd.rd_way = (state_q == ST_WAYS) && !sts.ways_done;
		cmd.eval_way = (state_q == ST_WAYS || state_q == ST_COMMIT) && rd_pend_q;
		cmd.commit = (state_q == ST_COMMIT);
		cmd.sw_rd = (state_q == ST_SWEEP);
		cmd.sw_eval = (state_q == ST_SWEEP || state_q == ST_SWLAST) && rd_pend_q;
		cmd.tick = take && (in_action == ACT_TICK);
		cmd.rsp_load = (state_q == ST_DONE) && !out_busy;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rd_pend_q <= 1'b0;
		end else begin
			rd_pend_q <= cmd.rd_way || cmd.sw_rd;
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						if (in_action <= ACT_TOUCH) begin
							state_q <= ST_HASH;
						end else if (in_action == ACT_SWEEP || in_action == ACT_CLEAR) begin
							state_q <= ST_SWEEP;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_HASH: if (sts.hash_done) state_q <= ST_WAYS;
				ST_WAYS: if (sts.ways_done) state_q <= ST_COMMIT;
				ST_COMMIT: state_q <= ST_DONE;
				ST_SWEEP: if (sts.sw_last) state_q <= ST_SWLAST;
				ST_SWLAST: state_q <= ST_DONE;
				ST_DONE: if (!out_busy) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

@@ rtl/core/ftwa_dp.sv @@
// Datapath of the flow table: hash unit, entry memories and sweep counter.
module ftwa_dp (
	input logic clk,
	input logic arst_n,
	input ftwa_pkg::cmd_t cmd,
	input ftwa_pkg::req_t req,
	input logic [31:0] hash_seed,
	input logic [31:0] idle_timeout,
	output ftwa_pkg::sts_t sts,
	output ftwa_pkg::rsp_t rsp
);
	import ftwa_pkg::*;

	// Memories (no reset; validity tracked by a separate memory cleared after reset).
	logic [63:0] mem_addr [ENTRIES];
	logic [31:0] mem_port [ENTRIES];
	logic [31:0] mem_stamp [ENTRIES];
	logic mem_valid [ENTRIES];

	req_t req_q;
	logic [31:0] a_q, b_q, c_q;
	logic [1:0] hstep_q;
	logic [31:0] now_q;
	logic [WAY_W:0] wcnt_q;
	logic [WAY_W-1:0] rway_q;
	logic [63:0] rd_addr_q;
	logic [31:0] rd_port_q;
	logic [31:0] rd_stamp_q;
	logic rd_valid_q;
	logic [ENT_W:0] sidx_q;
	logic [ENT_W-1:0] sent_q;
	logic hit_q, free_q;
	logic [WAY_W-1:0] hway_q, fway_q;
	logic [CNT_W-1:0] rem_q;
	logic clr_done_q;
	logic [ENT_W:0] clr_idx_q;

	logic [BKT_W-1:0] bkt;
	assign bkt = c_q[BKT_W-1:0];

	logic [31:0] iv;
	assign iv = hash_seed + 32'hdeadbeef + 32'd12;

	// Two mix rounds per cycle (one in the last step) give seven rounds plus final pick.
	logic [31:0] na, nb, nc;
	always_comb begin
		na = a_q; nb = b_q; nc = c_q;
		case (hstep_q)
			2'd0: begin
				nc = (nc ^ nb) - rotl(nb, 14);
				na = (na ^ nc) - rotl(nc, 11);
			end
			2'd1: begin
				nb = (nb ^ na) - rotl(na, 25);
				nc = (nc ^ nb) - rotl(nb, 16);
			end
			2'd2: begin
				na = (na ^ nc) - rotl(nc, 4);
				nb = (nb ^ na) - rotl(na, 14);
			end
			default: begin
				nc = (nc ^ nb) - rotl(nb, 24);
			end
		endcase
	end

	assign sts.hash_done = (hstep_q == 2'd3);
	assign sts.ways_done = (wcnt_q == WAYS[WAY_W:0]);
	assign sts.sw_last = (sidx_q == ENTRIES[ENT_W:0] - 1'b1);

	logic [ENT_W-1:0] rd_idx;
	assign rd_idx = cmd.sw_rd ? sidx_q[ENT_W-1:0] : {bkt, wcnt_q[WAY_W-1:0]};

	logic match;
	always_comb begin
		match = (rd_addr_q[63:32] == req_q.src_ip && rd_addr_q[31:0] == req_q.dst_ip &&
			rd_port_q[15:0] == req_q.src_port && rd_port_q[31:16] == req_q.dst_port) ||
			(rd_addr_q[63:32] == req_q.dst_ip && rd_addr_q[31:0] == req_q.src_ip &&
			rd_port_q[15:0] == req_q.dst_port && rd_port_q[31:16] == req_q.src_port);
	end

	logic aged;
	assign aged = (req_q.action == ACT_CLEAR) || ((now_q - rd_stamp_q) >= idle_timeout);

	logic [ENT_W-1:0] wr_idx;
	logic wr_new, wr_stamp, wr_inv;
	always_comb begin
		wr_new = 1'b0; wr_stamp = 1'b0; wr_inv = 1'b0;
		wr_idx = {bkt, hway_q};
		if (cmd.commit) begin
			if (hit_q) begin
				wr_stamp = (req_q.action == ACT_TOUCH);
			end else if (req_q.action == ACT_INSERT && free_q) begin
				wr_new = 1'b1;
				wr_idx = {bkt, fway_q};
			end
		end else if (cmd.sw_eval && rd_valid_q && aged) begin
			wr_inv = 1'b1;
			wr_idx = sent_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_way || cmd.sw_rd) begin
			rd_addr_q <= mem_addr[rd_idx];
			rd_port_q <= mem_port[rd_idx];
			rd_stamp_q <= mem_stamp[rd_idx];
		end
		if (wr_new) begin
			mem_addr[wr_idx] <= {req_q.src_ip, req_q.dst_ip};
			mem_port[wr_idx] <= {req_q.dst_port, req_q.src_port};
		end
		if (wr_new || wr_stamp) mem_stamp[wr_idx] <= now_q;
	end

	// Valid memory: one write port shared with a clearing pass after reset.
	always_ff @(posedge clk) begin
		if (!clr_done_q) begin
			mem_valid[clr_idx_q[ENT_W-1:0]] <= 1'b0;
		end else if (wr_new || wr_inv) begin
			mem_valid[wr_idx] <= wr_new;
		end
		if (cmd.rd_way || cmd.sw_rd) rd_valid_q <= mem_valid[rd_idx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_done_q <= 1'b0;
			clr_idx_q <= '0;
		end else begin
			if (!clr_done_q) begin
				clr_idx_q <= clr_idx_q + 1'b1;
				if (clr_idx_q == ENTRIES[ENT_W:0] - 1'b1) clr_done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_q <= '0;
			hstep_q <= '0;
			wcnt_q <= '0;
			sidx_q <= '0;
			rem_q <= '0;
			hit_q <= 1'b0;
			free_q <= 1'b0;
		end else begin
			if (cmd.tick) now_q <= now_q + 32'd1;
			if (cmd.load) begin
				hstep_q <= '0;
				wcnt_q <= '0;
				sidx_q <= '0;
				rem_q <= '0;
				hit_q <= 1'b0;
				free_q <= 1'b0;
			end
			if (cmd.hash_step) hstep_q <= hstep_q + 2'd1;
			if (cmd.rd_way) wcnt_q <= wcnt_q + 1'b1;
			if (cmd.sw_rd) sidx_q <= sidx_q + 1'b1;
			if (cmd.eval_way) begin
				if (rd_valid_q) begin
					if (!hit_q && match) hit_q <= 1'b1;
				end else if (!free_q) begin
					free_q <= 1'b1;
				end
			end
			if (wr_inv && rem_q != CNT_MAX) rem_q <= rem_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= req;
			a_q <= req.src_ip + iv;
			b_q <= (req.dst_ip ^ {24'd0, req.protocol}) + iv;
			c_q <= {req.dst_port, req.src_port} + iv;
		end else if (cmd.hash_step) begin
			a_q <= na; b_q <= nb; c_q <= nc;
		end
		if (cmd.rd_way) rway_q <= wcnt_q[WAY_W-1:0];
		if (cmd.sw_rd) sent_q <= sidx_q[ENT_W-1:0];
		if (cmd.eval_way) begin
			if (rd_valid_q) begin
				if (!hit_q && match) hway_q <= rway_q;
			end else if (!free_q) begin
				fway_q <= rway_q;
			end
		end
	end

	always_comb begin
		rsp = '0;
		if (req_q.action <= ACT_TOUCH) begin
			rsp.bucket = 10'(bkt);
			rsp.found = hit_q;
			rsp.inserted = !hit_q && free_q && (req_q.action == ACT_INSERT);
			rsp.table_full = !hit_q && !free_q && (req_q.action == ACT_INSERT);
			if (hit_q) rsp.way = 2'(hway_q);
			else if (rsp.inserted) rsp.way = 2'(fway_q);
		end else if (req_q.action == ACT_SWEEP || req_q.action == ACT_CLEAR) begin
			rsp.removed_count = rem_q;
		end
	end
endmodule

@@ rtl/core/flow_table_with_aging.sv @@
// Top level of the flow table with aging: hashed four-way connection table.
// Requests arrive on the in channel (in_valid, in_stall, in_data) and carry an
// action plus a flow tuple; each request yields exactly one response on the
// out channel (out_valid, out_stall, out_data).
// Lookup, insert and touch capture the request, run the jhash mix (two rounds
// per cycle, one in the last step), read once per way of the bucket and then
// commit. Age sweep and clear walk all 4096 entries one per cycle.
// One request is in flight at a time; the next request is taken once the
// response register is loaded and the controller returns to idle.
// After reset a clearing pass over all 4096 entries zeroes the valid memory; the
// request stall is held high during that pass. Configuration writes through
// the APB port are taken at any time.
// When the receiver stalls, the response stays in the output register and
// the block holds further requests off with in_stall.
module flow_table_with_aging (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input ftwa_pkg::req_t in_data,
	output logic out_valid,
	input logic out_stall,
	output ftwa_pkg::rsp_t out_data,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [2:2] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	import ftwa_pkg::*;

	logic [31:0] seed_q;
	logic [31:0] timeout_q;
	logic [ENT_W:0] boot_q;
	logic ready_q;
	cmd_t cmd;
	sts_t sts;
	rsp_t rsp;
	logic take;
	logic out_busy;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_TIMEOUT) ? timeout_q : seed_q;

	// Configuration registers are written in the APB access phase.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= '0;
			timeout_q <= 32'd1200000;
		end else if (psel && penable && pwrite) begin
			if (paddr[2] == REG_SEED) seed_q <= pwdata;
			else timeout_q <= pwdata;
		end
	end

	// Tracks the datapath's clearing pass so no request enters before it ends.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			boot_q <= '0;
			ready_q <= 1'b0;
		end else if (!ready_q) begin
			boot_q <= boot_q + 1'b1;
			if (boot_q == ENTRIES[ENT_W:0]) ready_q <= 1'b1;
		end
	end

	assign out_busy = out_valid && out_stall;

	logic ctl_valid;
	assign ctl_valid = in_valid && ready_q;
	assign in_stall = !(ready_q && take);

	ftwa_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(ctl_valid), .in_action(in_data.action),
		.out_busy(out_busy), .sts(sts), .take(take), .cmd(cmd)
	);

	ftwa_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .req(in_data), .hash_seed(seed_q),
		.idle_timeout(timeout_q), .sts(sts), .rsp(rsp)
	);

	// Output register: loaded once per request, cleared when taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.rsp_load) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rsp_load) out_data <= rsp;
	end
endmodule

@@ rtl/core/ftwa_chk.sv @@
// Port-level checker for the flow table, bound to the top level.
module ftwa_chk (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input ftwa_pkg::rsp_t out_data
);
	import ftwa_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled response changed");

	a_one_hot_res: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(out_data.inserted && out_data.table_full))
		else $error("inserted and full both set");

	a_ins_nfound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.inserted |-> !out_data.found)
		else $error("insert reported with a hit");

	a_accept_gap: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("back-to-back request accepted");
endmodule

bind flow_table_with_aging ftwa_chk u_ftwa_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);
